FILE: sv/trs_pkg.sv
package trs_pkg;

    // Fixed field widths
    localparam int ID_W        = 24;
    localparam int SEP_W       = 24;
    localparam int SLOT_W      = 5;
    localparam int STATUS_W    = 4;

    // Stream widths
    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 32;

    localparam logic [SEP_W-1:0] SEP_RESET = 24'd10000;

    typedef enum logic [1:0] {
        ACT_QUERY    = 2'd0,
        ACT_WR_GW    = 2'd1,
        ACT_WR_LOCAL = 2'd2,
        ACT_WR_ROUTE = 2'd3
    } t_action;

    // Codes up to ST_TABLE mean a gateway was chosen
    typedef enum logic [STATUS_W-1:0] {
        ST_TRUNK        = 4'd0,
        ST_PRIVATE      = 4'd1,
        ST_PREFIX       = 4'd2,
        ST_TABLE        = 4'd3,
        ST_LOCAL        = 4'd4,
        ST_NO_TRUNK     = 4'd5,
        ST_MULTI_TRUNK  = 4'd6,
        ST_NO_PRIVATE   = 4'd7,
        ST_NONE         = 4'd8,
        ST_MULTI_PREFIX = 4'd9
    } t_status;

endpackage

FILE: sv/talkgroup_route_selector.sv
// A route query's result passes through 3 register stages. Throughput: one item per
// cycle while the result side does not stall; table writes and queries may follow back
// to back. Result-side stalls hold every full stage; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous): all table entries invalid, pipeline empty,
// prefix_separation back to 10000. Table payload is not cleared.
module talkgroup_route_selector #(
    parameter int GATEWAY_SLOTS = 8,
    parameter int LOCAL_SLOTS   = 16,
    parameter int ROUTE_SLOTS   = 32,
    parameter int ID_BITS       = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: prefix_separation
    input  logic                                i_cfg_we,
    input  logic [trs_pkg::SEP_W-1:0]           i_cfg_wdata,
    // input items
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // slot[4:0], dst_id[28:5], gw_id[52:29], gw_trunking[53], gw_prefix[77:54],
    // gw_prefix_valid[78], gw_private_enable[79], entry_valid[80], zero pad[87:81]
    input  logic [trs_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // action[1:0], message_flag[2], private_call[3]
    input  logic [trs_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    // results
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // routed[0], chosen_gw[24:1], route_status[28:25], zero pad[31:29]
    output logic [trs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    // Identifiers are kept at ID_BITS, never wider than the 24-bit fields.
    localparam int IW = (ID_BITS < trs_pkg::ID_W) ? ID_BITS : trs_pkg::ID_W;

    // ------------------------------------------------------------------
    // Input unpack (identifiers masked to IW bits)
    // ------------------------------------------------------------------
    trs_pkg::t_action                in_action;
    logic [trs_pkg::SLOT_W-1:0]      in_slot;
    logic                            in_msg;
    logic                            in_priv;
    logic [IW-1:0]                   in_dst;
    logic [IW-1:0]                   in_gid;
    logic                            in_trunk;
    logic [IW-1:0]                   in_prefix;
    logic                            in_pvalid;
    logic                            in_penable;
    logic                            in_evalid;
    logic                            in_xfer;

    assign in_action  = trs_pkg::t_action'(i_s_axis_tuser[1:0]);
    assign in_msg     = i_s_axis_tuser[2];
    assign in_priv    = i_s_axis_tuser[3];
    assign in_slot    = i_s_axis_tdata[4:0];
    assign in_dst     = i_s_axis_tdata[5 +: IW];
    assign in_gid     = i_s_axis_tdata[29 +: IW];
    assign in_trunk   = i_s_axis_tdata[53];
    assign in_prefix  = i_s_axis_tdata[54 +: IW];
    assign in_pvalid  = i_s_axis_tdata[78];
    assign in_penable = i_s_axis_tdata[79];
    assign in_evalid  = i_s_axis_tdata[80];

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when
    // the stage after it moves. Writes are taken whenever stage 1 can load.
    // ------------------------------------------------------------------
    logic r1_v, r2_v, r3_v;
    logic ready1, ready2, ready3;

    assign ready3          = !r3_v || i_m_axis_tready;
    assign ready2          = !r2_v || ready3;
    assign ready1          = !r1_v || ready2;
    assign o_s_axis_tready = ready1;
    assign in_xfer         = i_s_axis_tvalid && ready1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [trs_pkg::SEP_W-1:0] r_sep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= trs_pkg::SEP_RESET;
        end else if (i_cfg_we) begin
            r_sep <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Tables. Valid and flag bits are reset; ids, prefixes and keys are not.
    // A cleared entry drops its flags so that nothing of it matches.
    // ------------------------------------------------------------------
    logic [GATEWAY_SLOTS-1:0] r_gw_valid, r_gw_trunk, r_gw_pvalid, r_gw_penable;
    logic [IW-1:0]            r_gw_id     [GATEWAY_SLOTS];
    logic [IW-1:0]            r_gw_prefix [GATEWAY_SLOTS];
    logic [LOCAL_SLOTS-1:0]   r_lt_valid;
    logic [IW-1:0]            r_lt_tg     [LOCAL_SLOTS];
    logic [ROUTE_SLOTS-1:0]   r_rt_valid;
    logic [IW-1:0]            r_rt_key    [ROUTE_SLOTS];
    logic [IW-1:0]            r_rt_gw     [ROUTE_SLOTS];

    logic wr_gw, wr_lt, wr_rt;

    assign wr_gw = in_xfer && (in_action == trs_pkg::ACT_WR_GW);
    assign wr_lt = in_xfer && (in_action == trs_pkg::ACT_WR_LOCAL);
    assign wr_rt = in_xfer && (in_action == trs_pkg::ACT_WR_ROUTE);

    // Slots beyond a table's depth match no entry, so such writes drop out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw_valid   <= '0;
            r_gw_trunk   <= '0;
            r_gw_pvalid  <= '0;
            r_gw_penable <= '0;
            r_lt_valid   <= '0;
            r_rt_valid   <= '0;
        end else begin
            for (int i = 0; i < GATEWAY_SLOTS; i++) begin
                if (wr_gw && (int'(in_slot) == i)) begin
                    r_gw_valid[i]   <= in_evalid;
                    r_gw_trunk[i]   <= in_evalid && in_trunk;
                    r_gw_pvalid[i]  <= in_evalid && in_pvalid;
                    r_gw_penable[i] <= in_evalid && in_penable;
                end
            end
            for (int i = 0; i < LOCAL_SLOTS; i++) begin
                if (wr_lt && (int'(in_slot) == i)) begin
                    r_lt_valid[i] <= in_evalid;
                end
            end
            for (int i = 0; i < ROUTE_SLOTS; i++) begin
                if (wr_rt && (int'(in_slot) == i)) begin
                    r_rt_valid[i] <= in_evalid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < GATEWAY_SLOTS; i++) begin
            if (wr_gw && (int'(in_slot) == i)) begin
                r_gw_id[i]     <= in_gid;
                r_gw_prefix[i] <= in_prefix;
            end
        end
        for (int i = 0; i < LOCAL_SLOTS; i++) begin
            if (wr_lt && (int'(in_slot) == i)) begin
                r_lt_tg[i] <= in_dst;
            end
        end
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (wr_rt && (int'(in_slot) == i)) begin
                r_rt_key[i] <= in_dst;
                r_rt_gw[i]  <= in_gid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 lookup: every table is read in the cycle the query transfers,
    // against the contents left by all earlier items. Everything later
    // stages need from the tables is copied into the pipeline here, so
    // later writes cannot disturb a query in flight.
    // ------------------------------------------------------------------
    logic [LOCAL_SLOTS-1:0]   lt_hit;
    logic [ROUTE_SLOTS-1:0]   rt_hit, rt_first;
    logic [IW-1:0]            rt_gw;
    logic [GATEWAY_SLOTS-1:0] gw_above;
    logic [IW-1:0]            gw_diff [GATEWAY_SLOTS];

    always_comb begin
        for (int i = 0; i < LOCAL_SLOTS; i++) begin
            lt_hit[i] = r_lt_valid[i] && (r_lt_tg[i] == in_dst);
        end
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
            rt_hit[i] = r_rt_valid[i] && (r_rt_key[i] == in_dst);
        end
        // lowest matching slot wins on duplicate keys
        rt_first = rt_hit & (~rt_hit + (ROUTE_SLOTS)'(1));
        rt_gw    = '0;
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
            rt_gw = rt_gw | (rt_first[i] ? r_rt_gw[i] : '0);
        end
        // prefix window, first half: dst strictly above the prefix
        for (int i = 0; i < GATEWAY_SLOTS; i++) begin
            gw_above[i] = r_gw_valid[i] && r_gw_pvalid[i] && (in_dst > r_gw_prefix[i]);
            gw_diff[i]  = in_dst - r_gw_prefix[i];
        end
    end

    logic                     r1_msg, r1_priv, r1_local, r1_rt_hit;
    logic [IW-1:0]            r1_rt_gw;
    logic [GATEWAY_SLOTS-1:0] r1_above, r1_trunk, r1_penable;
    logic [IW-1:0]            r1_diff [GATEWAY_SLOTS];
    logic [IW-1:0]            r1_id   [GATEWAY_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (ready1) begin
            r1_v <= in_xfer && (in_action == trs_pkg::ACT_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r1_msg     <= in_msg;
            r1_priv    <= in_priv;
            r1_local   <= |lt_hit;
            r1_rt_hit  <= |rt_hit;
            r1_rt_gw   <= rt_gw;
            r1_above   <= gw_above;
            r1_trunk   <= r_gw_trunk;
            r1_penable <= r_gw_penable;
            r1_diff    <= gw_diff;
            r1_id      <= r_gw_id;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: second half of the prefix window, distance below separation.
    // ------------------------------------------------------------------
    logic [GATEWAY_SLOTS-1:0] pfx_match;

    always_comb begin
        for (int i = 0; i < GATEWAY_SLOTS; i++) begin
            pfx_match[i] = r1_above[i] && ((trs_pkg::SEP_W)'(r1_diff[i]) < r_sep);
        end
    end

    logic                     r2_msg, r2_priv, r2_local, r2_rt_hit;
    logic [IW-1:0]            r2_rt_gw;
    logic [GATEWAY_SLOTS-1:0] r2_pfx, r2_trunk, r2_penable;
    logic [IW-1:0]            r2_id [GATEWAY_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (ready2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_v && ready2) begin
            r2_msg     <= r1_msg;
            r2_priv    <= r1_priv;
            r2_local   <= r1_local;
            r2_rt_hit  <= r1_rt_hit;
            r2_rt_gw   <= r1_rt_gw;
            r2_pfx     <= pfx_match;
            r2_trunk   <= r1_trunk;
            r2_penable <= r1_penable;
            r2_id      <= r1_id;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: decision. Message frames take precedence over private calls,
    // then local talkgroups, a single prefix hit and the route table; else multi-prefix or none.
    // ------------------------------------------------------------------
    logic [GATEWAY_SLOTS-1:0] trunk_first, priv_first;
    logic                     trunk_multi, pfx_multi;
    logic [IW-1:0]            trunk_id, priv_id, pfx_id;
    logic                     dec_routed;
    logic [IW-1:0]            dec_gw;
    trs_pkg::t_status         dec_status;

    always_comb begin
        trunk_first = r2_trunk & (~r2_trunk + (GATEWAY_SLOTS)'(1));
        priv_first  = r2_penable & (~r2_penable + (GATEWAY_SLOTS)'(1));
        trunk_multi = (r2_trunk & (r2_trunk - (GATEWAY_SLOTS)'(1))) != '0;
        pfx_multi   = (r2_pfx & (r2_pfx - (GATEWAY_SLOTS)'(1))) != '0;
        trunk_id    = '0;
        priv_id     = '0;
        pfx_id      = '0;
        for (int i = 0; i < GATEWAY_SLOTS; i++) begin
            trunk_id = trunk_id | (trunk_first[i] ? r2_id[i] : '0);
            priv_id  = priv_id  | (priv_first[i]  ? r2_id[i] : '0);
            pfx_id   = pfx_id   | (r2_pfx[i]      ? r2_id[i] : '0);
        end

        dec_routed = 1'b0;
        dec_gw     = '0;
        if (r2_msg) begin
            if (r2_trunk == '0) begin
                dec_status = trs_pkg::ST_NO_TRUNK;
            end else if (trunk_multi) begin
                dec_status = trs_pkg::ST_MULTI_TRUNK;
            end else begin
                dec_status = trs_pkg::ST_TRUNK;
                dec_routed = 1'b1;
                dec_gw     = trunk_id;
            end
        end else if (r2_priv) begin
            if (r2_penable == '0) begin
                dec_status = trs_pkg::ST_NO_PRIVATE;
            end else begin
                dec_status = trs_pkg::ST_PRIVATE;
                dec_routed = 1'b1;
                dec_gw     = priv_id;
            end
        end else if (r2_local) begin
            dec_status = trs_pkg::ST_LOCAL;
        end else if ((r2_pfx != '0) && !pfx_multi) begin
            // exactly one hit, so the OR-mux is that gateway's id
            dec_status = trs_pkg::ST_PREFIX;
            dec_routed = 1'b1;
            dec_gw     = pfx_id;
        end else if (r2_rt_hit) begin
            dec_status = trs_pkg::ST_TABLE;
            dec_routed = 1'b1;
            dec_gw     = r2_rt_gw;
        end else if (pfx_multi) begin
            dec_status = trs_pkg::ST_MULTI_PREFIX;
        end else begin
            dec_status = trs_pkg::ST_NONE;
        end
    end

    logic                     r3_routed;
    logic [IW-1:0]            r3_gw;
    trs_pkg::t_status         r3_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (ready3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_v && ready3) begin
            r3_routed <= dec_routed;
            r3_gw     <= dec_gw;
            r3_status <= dec_status;
        end
    end

    assign o_m_axis_tvalid = r3_v;
    assign o_m_axis_tdata  = {3'b000, r3_status, (trs_pkg::ID_W)'(r3_gw), r3_routed};

endmodule

FILE: sv/trs_checker.sv
module trs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [trs_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    logic                             routed;
    logic [trs_pkg::ID_W-1:0]         gw;
    logic [trs_pkg::STATUS_W-1:0]     status;

    assign routed = o_m_axis_tdata[0];
    assign gw     = o_m_axis_tdata[24:1];
    assign status = o_m_axis_tdata[28:25];

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (status <= trs_pkg::ST_MULTI_PREFIX))
        else $error("route_status out of range");

    a_routed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (routed == (status <= trs_pkg::ST_TABLE)))
        else $error("routed flag disagrees with route_status");

    a_unrouted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !routed) |-> (gw == '0))
        else $error("chosen_gw nonzero on unrouted result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind talkgroup_route_selector trs_checker u_trs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: sim/tb.sv
module tb;

    // Widths taken from the package
    localparam int ID_W        = trs_pkg::ID_W;
    localparam int SEP_W       = trs_pkg::SEP_W;
    localparam int SLOT_W      = trs_pkg::SLOT_W;
    localparam int IN_TDATA_W  = trs_pkg::IN_TDATA_W;
    localparam int IN_TUSER_W  = trs_pkg::IN_TUSER_W;
    localparam int OUT_TDATA_W = trs_pkg::OUT_TDATA_W;

    // Table depths, matching the block's defaults
    localparam int GW_SLOTS    = 8;
    localparam int LOCAL_SLOTS = 16;
    localparam int ROUTE_SLOTS = 32;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 6;
    localparam int PHASE_ITEMS  = 250;     // transfers per separation setting
    localparam int DRAIN_CYCLES = 8;       // settling time after the last result, with slack
    localparam int HOLD_CYCLES  = 300;     // long result-side hold-off
    localparam int HOT_IDS      = 8;       // small id pool so lookups actually hit
    localparam int N_DIRECTED   = 25;
    localparam int N_PHASES     = 6;
    localparam int RUN_LIMIT    = 5_000_000;

    localparam logic [ID_W-1:0]  ID_MAX  = '1;
    localparam logic [SEP_W-1:0] SEP_MAX = '1;

    // One input item, fields as the block sees them
    typedef struct packed {
        trs_pkg::t_action  action;
        logic [SLOT_W-1:0] slot;
        logic              msg;
        logic              priv;
        logic [ID_W-1:0]   dst;
        logic [ID_W-1:0]   gw_id;
        logic              trunk;
        logic [ID_W-1:0]   prefix;
        logic              prefix_ok;
        logic              priv_en;
        logic              valid;
    } t_talk_frame;

    // One route decision
    typedef struct packed {
        logic             routed;
        logic [ID_W-1:0]  gw_id;
        trs_pkg::t_status status;
    } t_route_result;

    // Directed table row: the decision is typed in only when typed is set
    typedef struct packed {
        t_talk_frame   frame;
        logic          typed;
        t_route_result result;
    } t_frame_row;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic            trunk;
        logic [ID_W-1:0] prefix;
        logic            prefix_ok;
        logic            priv_en;
    } t_gw_slot;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] tg;
    } t_local_slot;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] gw_id;
    } t_route_slot;

    localparam t_route_result NOT_TYPED = '{1'b0, 24'h0, trs_pkg::ST_NONE};

    // DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [SEP_W-1:0]       i_cfg_wdata;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // slot, dst_id, gw_id, gw_trunking, gw_prefix, gw_prefix_valid,
    // gw_private_enable, entry_valid, zero pad (lowest bit up)
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    // action, message_flag, private_call (lowest bit up)
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // routed, chosen_gw, route_status, zero pad (lowest bit up)
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Shadow copy of the block's tables and separation register
    t_gw_slot      gw_tab    [GW_SLOTS];
    t_local_slot   local_tab [LOCAL_SLOTS];
    t_route_slot   route_tab [ROUTE_SLOTS];
    logic [SEP_W-1:0] sep_now;

    t_route_result pending_routes [$];   // decisions still owed by the block
    logic [ID_W-1:0] hot_ids [HOT_IDS];
    bit            failed;
    bit            hold_off_req;
    int unsigned   burst_left;

    talkgroup_route_selector #(
        .GATEWAY_SLOTS (GW_SLOTS),
        .LOCAL_SLOTS   (LOCAL_SLOTS),
        .ROUTE_SLOTS   (ROUTE_SLOTS),
        .ID_BITS       (ID_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Route decision, in priority order: message frame, private call,
    // local talkgroup, unique prefix window, route table.
    // ------------------------------------------------------------------
    function automatic t_route_result decide_route(t_talk_frame f);
        int unsigned     hits;
        logic [ID_W-1:0] first_id;
        t_route_result   r;
        hits     = 0;
        first_id = '0;
        r        = NOT_TYPED;
        // message frames need exactly one trunking gateway
        if (f.msg) begin
            foreach (gw_tab[i]) begin
                if (gw_tab[i].valid && gw_tab[i].trunk) begin
                    if (hits == 0) first_id = gw_tab[i].id;
                    hits++;
                end
            end
            if (hits == 1) begin
                r = '{1'b1, first_id, trs_pkg::ST_TRUNK};
            end else if (hits == 0) begin
                r.status = trs_pkg::ST_NO_TRUNK;
            end else begin
                r.status = trs_pkg::ST_MULTI_TRUNK;
            end
            return r;
        end
        // private call: lowest slot that takes private calls
        if (f.priv) begin
            foreach (gw_tab[i]) begin
                if (gw_tab[i].valid && gw_tab[i].priv_en) begin
                    r = '{1'b1, gw_tab[i].id, trs_pkg::ST_PRIVATE};
                    return r;
                end
            end
            r.status = trs_pkg::ST_NO_PRIVATE;
            return r;
        end
        // local talkgroups stay here
        foreach (local_tab[i]) begin
            if (local_tab[i].valid && local_tab[i].tg == f.dst) begin
                r.status = trs_pkg::ST_LOCAL;
                return r;
            end
        end
        // prefix window is open at both ends: 0 < dst - prefix < separation
        foreach (gw_tab[i]) begin
            if (gw_tab[i].valid && gw_tab[i].prefix_ok && f.dst > gw_tab[i].prefix &&
                (f.dst - gw_tab[i].prefix) < sep_now) begin
                if (hits == 0) first_id = gw_tab[i].id;
                hits++;
            end
        end
        if (hits == 1) begin
            r = '{1'b1, first_id, trs_pkg::ST_PREFIX};
            return r;
        end
        // fall back on the route table, lowest matching slot wins
        foreach (route_tab[i]) begin
            if (route_tab[i].valid && route_tab[i].key == f.dst) begin
                r = '{1'b1, route_tab[i].gw_id, trs_pkg::ST_TABLE};
                return r;
            end
        end
        r.status = (hits > 1) ? trs_pkg::ST_MULTI_PREFIX : trs_pkg::ST_NONE;
        return r;
    endfunction

    // Table writes: out-of-range slots are dropped, entry_valid 0 wipes the entry
    function automatic void apply_table_write(t_talk_frame f);
        case (f.action)
            trs_pkg::ACT_WR_GW: begin
                if (f.slot < GW_SLOTS) begin
                    gw_tab[f.slot] = '0;
                    if (f.valid)
                        gw_tab[f.slot] = '{1'b1, f.gw_id, f.trunk, f.prefix,
                                           f.prefix_ok, f.priv_en};
                end
            end
            trs_pkg::ACT_WR_LOCAL: begin
                if (f.slot < LOCAL_SLOTS) begin
                    local_tab[f.slot] = '0;
                    if (f.valid)
                        local_tab[f.slot] = '{1'b1, f.dst};
                end
            end
            trs_pkg::ACT_WR_ROUTE: begin
                if (f.slot < ROUTE_SLOTS) begin
                    route_tab[f.slot] = '0;
                    if (f.valid)
                        route_tab[f.slot] = '{1'b1, f.dst, f.gw_id};
                end
            end
            default: ;
        endcase
    endfunction

    // Item builders for the directed table
    function automatic t_talk_frame q_frame(logic msg, logic priv, logic [ID_W-1:0] dst);
        t_talk_frame f;
        f        = '0;
        f.action = trs_pkg::ACT_QUERY;
        f.msg    = msg;
        f.priv   = priv;
        f.dst    = dst;
        return f;
    endfunction

    function automatic t_talk_frame w_gw(logic [SLOT_W-1:0] slot, logic [ID_W-1:0] id,
                                         logic trunk, logic [ID_W-1:0] prefix,
                                         logic pok, logic pen, logic valid);
        t_talk_frame f;
        f           = '0;
        f.action    = trs_pkg::ACT_WR_GW;
        f.slot      = slot;
        f.gw_id     = id;
        f.trunk     = trunk;
        f.prefix    = prefix;
        f.prefix_ok = pok;
        f.priv_en   = pen;
        f.valid     = valid;
        return f;
    endfunction

    function automatic t_talk_frame w_local(logic [SLOT_W-1:0] slot, logic [ID_W-1:0] tg,
                                            logic valid);
        t_talk_frame f;
        f        = '0;
        f.action = trs_pkg::ACT_WR_LOCAL;
        f.slot   = slot;
        f.dst    = tg;
        f.valid  = valid;
        return f;
    endfunction

    function automatic t_talk_frame w_route(logic [SLOT_W-1:0] slot, logic [ID_W-1:0] key,
                                            logic [ID_W-1:0] gw, logic valid);
        t_talk_frame f;
        f        = '0;
        f.action = trs_pkg::ACT_WR_ROUTE;
        f.slot   = slot;
        f.dst    = key;
        f.gw_id  = gw;
        f.valid  = valid;
        return f;
    endfunction

    // Destination / key picker: aims at hot ids and at both edges of
    // some gateway's prefix window, with plain noise mixed in.
    function automatic logic [ID_W-1:0] aim_dst();
        t_gw_slot g;
        g = gw_tab[$urandom_range(0, GW_SLOTS - 1)];
        case ($urandom_range(0, 5))
            0:       return ID_W'($urandom);
            1, 2:    return hot_ids[$urandom_range(0, HOT_IDS - 1)];
            3:       return g.prefix + ID_W'($urandom_range(0, sep_now));
            4:       return g.prefix + sep_now - ID_W'($urandom_range(0, 2));
            default: return g.prefix + ID_W'($urandom_range(0, 2));
        endcase
    endfunction

    // Random item: about half queries, the rest table writes that keep
    // the tables populated with ids the queries will run into.
    function automatic t_talk_frame random_frame();
        t_talk_frame f;
        int unsigned pick;
        pick        = $urandom_range(0, 99);
        f.action    = (pick < 55) ? trs_pkg::ACT_QUERY :
                      (pick < 70) ? trs_pkg::ACT_WR_GW :
                      (pick < 85) ? trs_pkg::ACT_WR_LOCAL : trs_pkg::ACT_WR_ROUTE;
        f.slot      = SLOT_W'($urandom);
        f.msg       = ($urandom_range(0, 4) == 0);
        f.priv      = ($urandom_range(0, 4) == 0);
        f.dst       = aim_dst();
        f.gw_id     = ID_W'($urandom);
        f.trunk     = ($urandom_range(0, 4) == 0);
        // prefixes mostly sit just below a hot id so windows overlap
        f.prefix    = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) :
                      hot_ids[$urandom_range(0, HOT_IDS - 1)] -
                      ID_W'($urandom_range(0, sep_now));
        f.prefix_ok = ($urandom_range(0, 9) < 7);
        f.priv_en   = ($urandom_range(0, 9) < 3);
        f.valid     = ($urandom_range(0, 9) != 0);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. The item
    // is predicted at the edge where its transfer happens.
    // ------------------------------------------------------------------
    task automatic offer_frame(input t_talk_frame f, input logic typed,
                               input t_route_result typed_res);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                       $urandom_range(1, 12);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'b0, f.valid, f.priv_en, f.prefix_ok, f.prefix, f.trunk,
                            f.gw_id, f.dst, f.slot};
        i_s_axis_tuser  <= {f.priv, f.msg, f.action};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (f.action == trs_pkg::ACT_QUERY)
            pending_routes.push_back(typed ? typed_res : decide_route(f));
        else
            apply_table_write(f);
    endtask

    // Stop offering until the block owes nothing, then let writes settle
    task automatic wait_routes_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_routes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the block idle
    task automatic write_separation(input logic [SEP_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sep_now = v;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches between a few modes; a hold-off
    // request parks tready low until rx_hold_left runs out so the pipe backs up.
    // ------------------------------------------------------------------
    int unsigned rx_mode, rx_mode_left, rx_hold_left;

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            rx_hold_left = HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       i_m_axis_tready <= 1'b1;                        // no stalls
                1:       i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0); // heavy stalls
                default: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transfer against the oldest decision
    // ------------------------------------------------------------------
    t_route_result got_route, want_route;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_route = '{o_m_axis_tdata[0], o_m_axis_tdata[24:1],
                          trs_pkg::t_status'(o_m_axis_tdata[28:25])};
            if (pending_routes.size() == 0) begin
                $error("result transfer with no decision pending: tdata %h", o_m_axis_tdata);
                failed = 1'b1;
            end else begin
                want_route = pending_routes.pop_front();
                if (got_route.routed !== want_route.routed) begin
                    $error("routed: expected %0d, got %0d", want_route.routed, got_route.routed);
                    failed = 1'b1;
                end
                if (got_route.gw_id !== want_route.gw_id) begin
                    $error("chosen_gw: expected %h, got %h", want_route.gw_id, got_route.gw_id);
                    failed = 1'b1;
                end
                if (got_route.status !== want_route.status) begin
                    $error("route_status: expected %0d, got %0d",
                           want_route.status, got_route.status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        #RUN_LIMIT;
        $display("talkgroup_route_selector: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table at reset separation, then one
    // random phase per separation setting with the block drained between.
    // ------------------------------------------------------------------
    t_frame_row       directed_rows [N_DIRECTED];
    logic [SEP_W-1:0] phase_sep [N_PHASES];

    initial begin
        int unsigned counted;
        t_talk_frame f;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        failed          = 1'b0;
        hold_off_req    = 1'b0;
        burst_left      = 4;
        rx_mode_left    = 0;
        rx_hold_left    = 0;
        sep_now         = trs_pkg::SEP_RESET;
        foreach (gw_tab[i])    gw_tab[i]    = '0;
        foreach (local_tab[i]) local_tab[i] = '0;
        foreach (route_tab[i]) route_tab[i] = '0;
        foreach (hot_ids[i])   hot_ids[i]   = ID_W'($urandom);

        // Typed decisions are the ones obvious from the tables at that row
        directed_rows = '{
            // empty tables after reset
            '{q_frame(1'b1, 1'b0, 24'h0),      1'b1, '{1'b0, 24'h0, trs_pkg::ST_NO_TRUNK}},
            '{q_frame(1'b0, 1'b1, 24'h0),      1'b1, '{1'b0, 24'h0, trs_pkg::ST_NO_PRIVATE}},
            '{q_frame(1'b0, 1'b0, 24'h0),      1'b1, '{1'b0, 24'h0, trs_pkg::ST_NONE}},
            // two trunking gateways, plus a write past the table end
            '{w_gw(5'd0, ID_MAX, 1'b1, 24'h0, 1'b1, 1'b1, 1'b1),        1'b0, NOT_TYPED},
            '{w_gw(5'd7, 24'h1, 1'b1, 24'd100, 1'b1, 1'b0, 1'b1),       1'b0, NOT_TYPED},
            '{w_gw(5'd8, 24'habcdef, 1'b1, 24'h0, 1'b1, 1'b1, 1'b1),    1'b0, NOT_TYPED},
            '{q_frame(1'b1, 1'b0, 24'h0),      1'b1, '{1'b0, 24'h0, trs_pkg::ST_MULTI_TRUNK}},
            // both flags: message wins
            '{q_frame(1'b1, 1'b1, 24'h0),      1'b1, '{1'b0, 24'h0, trs_pkg::ST_MULTI_TRUNK}},
            '{q_frame(1'b0, 1'b1, 24'h0),      1'b1, '{1'b1, ID_MAX, trs_pkg::ST_PRIVATE}},
            // clearing slot 7 leaves a single trunk
            '{w_gw(5'd7, 24'h1, 1'b1, 24'd100, 1'b1, 1'b1, 1'b0),       1'b0, NOT_TYPED},
            '{q_frame(1'b1, 1'b0, 24'h0),      1'b1, '{1'b1, ID_MAX, trs_pkg::ST_TRUNK}},
            '{q_frame(1'b0, 1'b0, 24'd5000),   1'b0, NOT_TYPED},
            // local talkgroup shadows the prefix match; slot 16 is out of range
            '{w_local(5'd15, 24'd5000, 1'b1),  1'b0, NOT_TYPED},
            '{w_local(5'd16, 24'd7, 1'b1),     1'b0, NOT_TYPED},
            '{q_frame(1'b0, 1'b0, 24'd5000),   1'b1, '{1'b0, 24'h0, trs_pkg::ST_LOCAL}},
            '{q_frame(1'b0, 1'b0, 24'd7),      1'b0, NOT_TYPED},
            // overlapping windows, no route yet
            '{w_gw(5'd3, 24'h123456, 1'b0, 24'd1, 1'b1, 1'b0, 1'b1),    1'b0, NOT_TYPED},
            '{q_frame(1'b0, 1'b0, 24'd6),      1'b1, '{1'b0, 24'h0, trs_pkg::ST_MULTI_PREFIX}},
            // duplicate keys, lowest slot should win
            '{w_route(5'd31, 24'd6, 24'h654321, 1'b1), 1'b0, NOT_TYPED},
            '{w_route(5'd0, 24'd6, 24'h000001, 1'b1),  1'b0, NOT_TYPED},
            '{q_frame(1'b0, 1'b0, 24'd6),      1'b0, NOT_TYPED},
            '{q_frame(1'b0, 1'b0, ID_MAX),     1'b1, '{1'b0, 24'h0, trs_pkg::ST_NONE}},
            '{w_route(5'd0, 24'd6, 24'h000001, 1'b0),  1'b0, NOT_TYPED},
            '{q_frame(1'b0, 1'b0, 24'd6),      1'b0, NOT_TYPED},
            // dst - prefix equal to the separation is outside the window
            '{q_frame(1'b0, 1'b0, 24'd10000),  1'b0, NOT_TYPED}
        };

        // Separation settings: both extremes, narrow, mid, anything, reset value
        phase_sep[0] = 24'd1;
        phase_sep[1] = SEP_MAX;
        phase_sep[2] = SEP_W'($urandom_range(2, 64));
        phase_sep[3] = SEP_W'($urandom_range(1000, 200000));
        phase_sep[4] = SEP_W'($urandom_range(1, SEP_MAX));
        phase_sep[5] = trs_pkg::SEP_RESET;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            offer_frame(directed_rows[n].frame, directed_rows[n].typed,
                        directed_rows[n].result);

        foreach (phase_sep[p]) begin
            wait_routes_drained();
            write_separation(phase_sep[p]);
            foreach (hot_ids[i]) hot_ids[i] = ID_W'($urandom);
            hot_ids[0] = '0;
            hot_ids[1] = ID_MAX;
            // long receiver hold-off while the sender keeps pushing
            if (p == 1 || p == 4) begin
                hold_off_req = 1'b1;
                burst_left   = 80;
            end
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                f = random_frame();
                offer_frame(f, 1'b0, NOT_TYPED);
                counted++;
            end
        end

        wait_routes_drained();
        if (!failed)
            $display("talkgroup_route_selector: match");
        else
            $display("talkgroup_route_selector: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
sv/trs_pkg.sv
sv/talkgroup_route_selector.sv
sv/trs_checker.sv
sim/tb.sv
